@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qse_pkg.sv @@
`timescale 1ns / 1ps
package qse_pkg;
	localparam int VALUE_W          = 32;
	localparam int MAX_ELEMENTS_DEF = 64;
endpackage

@@ hdl/qse_in_if.sv @@
`timescale 1ns / 1ps
interface qse_in_if import qse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

@@ hdl/qse_out_if.sv @@
`timescale 1ns / 1ps
interface qse_out_if import qse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      end_of_run;

	modport source (output valid, sorted_value, end_of_run, input ready);
	modport sink (input valid, sorted_value, end_of_run, output ready);
endinterface

@@ hdl/qse_ram.sv @@
`timescale 1ns / 1ps
module qse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/qse_sort.sv @@
`timescale 1ns / 1ps
module qse_sort import qse_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   count,
	output logic                                done,
	output logic                                st_we,
	output logic [$clog2(MAX_ELEMENTS)-1:0]     st_waddr,
	output logic [VALUE_W-1:0]                  st_wdata,
	output logic [$clog2(MAX_ELEMENTS)-1:0]     st_raddr,
	input  logic [VALUE_W-1:0]                  st_rdata
);
	localparam int IW  = $clog2(MAX_ELEMENTS);
	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int SPW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_POP, S_RANGE, S_PIV, S_SCANL, S_SCANR,
		S_SWAP1, S_SWAP2, S_FIN1, S_FIN2, S_PUSHR
	} state_t;

	state_t                    state_q;
	logic [SPW-1:0]            sp_q;
	logic [IW-1:0]             lo_q, hi_q, i_q;
	logic [IW:0]               j_q;
	logic signed [VALUE_W-1:0] piv_q, vi_q, vj_q;
	logic                      done_q;

	logic                      stk_we;
	logic [IW-1:0]             stk_waddr, stk_raddr;
	logic [2*IW-1:0]           stk_wdata, stk_rdata;

	logic [SPW-1:0]            sp_dec;
	logic [CW-1:0]             count_dec;
	logic [IW-1:0]             rng_lo, rng_hi, i_inc, lo_inc;
	logic [IW:0]               j_dec, j_inc;
	logic signed [VALUE_W-1:0] rd_val;
	logic                      sp_room, left_go, right_go, push_left, push_right;

	assign sp_dec     = sp_q - 1'b1;
	assign count_dec  = count - 1'b1;
	assign rng_lo     = stk_rdata[IW-1:0];
	assign rng_hi     = stk_rdata[2*IW-1:IW];
	assign i_inc      = i_q + 1'b1;
	assign lo_inc     = lo_q + 1'b1;
	assign j_dec      = j_q - 1'b1;
	assign j_inc      = j_q + 1'b1;
	assign rd_val     = $signed(st_rdata);
	assign sp_room    = sp_q < SPW'(MAX_ELEMENTS);
	assign left_go    = (i_q < hi_q) && (rd_val < piv_q);
	assign right_go   = (j_q > {1'b0, lo_q}) && (piv_q < rd_val);
	assign push_left  = (j_q > {1'b0, lo_inc}) && (lo_inc != '0) && sp_room;
	assign push_right = (j_inc < {1'b0, hi_q}) && sp_room;
	assign done       = done_q;

	qse_ram #(
		.WIDTH(2 * IW),
		.DEPTH(MAX_ELEMENTS)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	always_comb begin
		st_we     = 1'b0;
		st_waddr  = '0;
		st_wdata  = '0;
		st_raddr  = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				stk_we    = start && (count >= CW'(2));
				stk_wdata = {count_dec[IW-1:0], {IW{1'b0}}};
			end
			S_POP: begin
				stk_raddr = sp_dec[IW-1:0];
			end
			S_RANGE: begin
				st_raddr = rng_lo;
			end
			S_PIV: begin
				st_raddr = lo_inc;
			end
			S_SCANL: begin
				st_raddr = left_go ? i_inc : j_dec[IW-1:0];
			end
			S_SCANR: begin
				st_raddr = j_dec[IW-1:0];
			end
			S_SWAP1: begin
				st_we    = 1'b1;
				st_waddr = j_q[IW-1:0];
				st_wdata = vi_q;
			end
			S_SWAP2: begin
				st_we    = 1'b1;
				st_waddr = i_q;
				st_wdata = vj_q;
				st_raddr = i_inc;
			end
			S_FIN1: begin
				st_we    = 1'b1;
				st_waddr = lo_q;
				st_wdata = vj_q;
			end
			S_FIN2: begin
				st_we     = 1'b1;
				st_waddr  = j_q[IW-1:0];
				st_wdata  = piv_q;
				stk_we    = push_left;
				stk_waddr = sp_q[IW-1:0];
				stk_wdata = {j_dec[IW-1:0], lo_q};
			end
			S_PUSHR: begin
				stk_we    = push_right;
				stk_waddr = sp_q[IW-1:0];
				stk_wdata = {hi_q, j_inc[IW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			piv_q   <= '0;
			vi_q    <= '0;
			vj_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (count < CW'(2)) begin
							done_q <= 1'b1;
						end else begin
							sp_q    <= SPW'(1);
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sp_q    <= sp_dec;
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					lo_q    <= rng_lo;
					hi_q    <= rng_hi;
					state_q <= (rng_lo >= rng_hi) ? S_POP : S_PIV;
				end
				S_PIV: begin
					piv_q   <= rd_val;
					i_q     <= lo_inc;
					j_q     <= {1'b0, hi_q} + 1'b1;
					state_q <= S_SCANL;
				end
				S_SCANL: begin
					if (left_go) begin
						i_q <= i_inc;
					end else begin
						vi_q    <= rd_val;
						j_q     <= j_dec;
						state_q <= S_SCANR;
					end
				end
				S_SCANR: begin
					if (right_go) begin
						j_q <= j_dec;
					end else begin
						vj_q    <= rd_val;
						state_q <= ({1'b0, i_q} < j_q) ? S_SWAP1 : S_FIN1;
					end
				end
				S_SWAP1: begin
					state_q <= S_SWAP2;
				end
				S_SWAP2: begin
					i_q     <= i_inc;
					state_q <= S_SCANL;
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if (push_left) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_PUSHR;
				end
				S_PUSHR: begin
					if (push_right) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_POP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hdl/quicksort_engine_core.sv @@
// quicksort_engine_core: sorts a set of signed 32-bit values ascending.
// elements (sink): one value per request; last marks the final value of a
// set. A set is closed by last or when it reaches MAX_ELEMENTS values.
// Loading never stalls the sender; ready is high only while loading.
// results (source): the set in ascending order, one value per request,
// with end_of_run on the final value. After end_of_run is taken the block
// returns to loading at once.
// Sorting runs in place in a single-port-write store memory with a
// registered read, plus a range stack memory. Each partition step scans
// entries from both ends, exchanges each out-of-order pair with two
// store writes and ends its range by placing the pivot and pushing the
// subranges on the stack. Emission alternates a capture state and a
// show state, so results are not offered back to back.
// A stalled receiver holds the current result in its output register and
// freezes emission; no new values are taken until the set is drained.
// Reset empties the block; it comes up ready to load a new set.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quicksort_engine_core import qse_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	qse_in_if.sink   elements,
	qse_out_if.source results
);
	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [2:0] {
		T_LOAD, T_SORT, T_FETCH, T_CAPT, T_SHOW
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q, n_q;
	logic [IW-1:0]             k_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_end_q;

	logic                      acc, fin;
	logic [CW-1:0]             cnt_inc, k_inc;

	logic                      st_we;
	logic [IW-1:0]             st_waddr, st_raddr;
	logic [VALUE_W-1:0]        st_wdata, st_rdata;

	logic                      sort_we, sort_done;
	logic [IW-1:0]             sort_waddr, sort_raddr;
	logic [VALUE_W-1:0]        sort_wdata;

	assign acc     = elements.valid && elements.ready;
	assign cnt_inc = cnt_q + 1'b1;
	assign fin     = elements.last || (cnt_inc == CW'(MAX_ELEMENTS));
	assign k_inc   = CW'(k_q) + 1'b1;

	assign elements.ready       = (state_q == T_LOAD);
	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.end_of_run   = out_end_q;

	qse_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	qse_sort #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc && fin),
		.count   (cnt_inc),
		.done    (sort_done),
		.st_we   (sort_we),
		.st_waddr(sort_waddr),
		.st_wdata(sort_wdata),
		.st_raddr(sort_raddr),
		.st_rdata(st_rdata)
	);

	// store port arbitration
	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = '0;
		st_raddr = '0;
		unique case (state_q)
			T_LOAD: begin
				st_we    = acc;
				st_waddr = cnt_q[IW-1:0];
				st_wdata = elements.value;
			end
			T_SORT: begin
				st_we    = sort_we;
				st_waddr = sort_waddr;
				st_wdata = sort_wdata;
				st_raddr = sort_raddr;
			end
			T_FETCH: begin
				st_raddr = k_q;
			end
			T_SHOW: begin
				st_raddr = k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				T_LOAD: begin
					if (acc) begin
						if (fin) begin
							n_q     <= cnt_inc;
							cnt_q   <= '0;
							state_q <= T_SORT;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				T_SORT: begin
					if (sort_done) begin
						k_q     <= '0;
						state_q <= T_FETCH;
					end
				end
				T_FETCH: begin
					state_q <= T_CAPT;
				end
				T_CAPT: begin
					out_value_q <= $signed(st_rdata);
					out_end_q   <= (k_inc == n_q);
					out_valid_q <= 1'b1;
					state_q     <= T_SHOW;
				end
				T_SHOW: begin
					if (results.ready) begin
						out_valid_q <= 1'b0;
						if (out_end_q) begin
							state_q <= T_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= T_CAPT;
						end
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_load_vs_emit, clk, arst_n, elements.ready && results.valid, "loading while emitting")
	`ASSERT_NEXT(a_reload_after_end, clk, arst_n, results.valid && results.ready && results.end_of_run, elements.ready, "not ready after end of run")
	`ASSERT_IMPLY(a_done_in_sort, clk, arst_n, sort_done, state_q == T_SORT, "sort done outside sort phase")
	`ASSERT_NEVER(a_count_range, clk, arst_n, cnt_q >= CW'(MAX_ELEMENTS), "element count out of range")
endmodule
